// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the converter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define HSL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define HSL_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/hsl_pkg.sv =====
// shared constants and types for the hsl to rgb converter
`default_nettype none
package hsl_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HUE_W     = FRAC_BITS;
  localparam int VAL_W     = FRAC_BITS + 1;
  localparam int X6_W      = HUE_W + 3;
  localparam int P1_W      = 2 * VAL_W + 1;
  localparam int P3_W      = 2 * VAL_W;

  localparam int IN_BITS   = HUE_W + 2 * VAL_W;
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 3 * VAL_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;
  localparam logic [HUE_W-1:0] THIRD = HUE_W'(((2 ** FRAC_BITS) + 1) / 3);
  localparam logic [HUE_W-1:0] ONE_MINUS_THIRD =
    HUE_W'((2 ** FRAC_BITS) - (((2 ** FRAC_BITS) + 1) / 3));

  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_HIGH = 2'd1,
    SEG_FALL = 2'd2,
    SEG_LOW  = 2'd3
  } seg_e;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

endpackage
`default_nettype wire

// ===== rtl/core/hsl_to_rgb_converter.sv =====
// hsl to rgb converter top level: stream ports and pipeline flow control
//
//   channel  dir  beat fields (low bit first)
//   s_axis   in   hue[15:0] saturation[32:16] lightness[49:33], zero pad to 56
//   m_axis   out  red[16:0] green[33:17] blue[50:34], zero pad to 56
//
// four register stages: multiply for the intermediates, finish the
// intermediates and pick the hue segment, ramp multiply, final select
// one beat per clock in and out while m_axis does not stall
// rst_ni clears only the stage valid bits, datapath registers are not reset
// a stall at m_axis fills empty stages first, s_axis_tready drops only
// when all four stages hold a beat
`default_nettype none
`include "assert_macros.svh"
module hsl_to_rgb_converter import hsl_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // hue, saturation, lightness, zero pad
  input  wire logic [IN_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // red, green, blue, zero pad
  output logic      [OUT_W-1:0] m_axis_tdata_o
);

  logic [3:0] valid_q, valid_d;
  logic [3:0] rdy;
  pipe_en_t   en;

  logic [HUE_W-1:0] hue, x_red, x_green, x_blue;
  logic [VAL_W-1:0] saturation, lightness;
  logic [VAL_W-1:0] d, t1, t2, light;
  logic             grey;
  logic [VAL_W-1:0] red, green, blue;

  // a stage may load when it is empty or its contents move on
  always_comb begin
    rdy[3] = !valid_q[3] || m_axis_tready_i;
    rdy[2] = !valid_q[2] || rdy[3];
    rdy[1] = !valid_q[1] || rdy[2];
    rdy[0] = !valid_q[0] || rdy[1];
    en.s1  = rdy[0];
    en.s2  = rdy[1];
    en.s3  = rdy[2];
    en.s4  = rdy[3];
    valid_d[0] = rdy[0] ? s_axis_tvalid_i : valid_q[0];
    valid_d[1] = rdy[1] ? valid_q[0] : valid_q[1];
    valid_d[2] = rdy[2] ? valid_q[1] : valid_q[2];
    valid_d[3] = rdy[3] ? valid_q[2] : valid_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign hue        = s_axis_tdata_i[HUE_W-1:0];
  assign saturation = s_axis_tdata_i[HUE_W+VAL_W-1:HUE_W];
  assign lightness  = s_axis_tdata_i[HUE_W+2*VAL_W-1:HUE_W+VAL_W];

  hsl_inter u_inter (
    .clk_i        (clk_i),
    .en_i         (en),
    .hue_i        (hue),
    .saturation_i (saturation),
    .lightness_i  (lightness),
    .x_red_o      (x_red),
    .x_green_o    (x_green),
    .x_blue_o     (x_blue),
    .d_o          (d),
    .t1_o         (t1),
    .t2_o         (t2),
    .light_o      (light),
    .grey_o       (grey)
  );

  hsl_chan u_chan_red (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (x_red),
    .d_i     (d),
    .t1_i    (t1),
    .t2_i    (t2),
    .light_i (light),
    .grey_i  (grey),
    .value_o (red)
  );

  hsl_chan u_chan_green (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (x_green),
    .d_i     (d),
    .t1_i    (t1),
    .t2_i    (t2),
    .light_i (light),
    .grey_i  (grey),
    .value_o (green)
  );

  hsl_chan u_chan_blue (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (x_blue),
    .d_i     (d),
    .t1_i    (t1),
    .t2_i    (t2),
    .light_i (light),
    .grey_i  (grey),
    .value_o (blue)
  );

  assign s_axis_tready_o = rdy[0];
  assign m_axis_tvalid_o = valid_q[3];
  assign m_axis_tdata_o  = OUT_W'({blue, green, red});

  `HSL_ASSERT(a_ready_low_full, !s_axis_tready_o |-> (valid_q == 4'b1111), "input stalled with an empty stage")
  `HSL_ASSERT(a_out_from_stage3, $rose(m_axis_tvalid_o) |-> $past(valid_q[2]), "output beat without a predecessor")
  `HSL_ASSERT(a_out_in_range, m_axis_tvalid_o |-> (red <= ONE && green <= ONE && blue <= ONE), "channel above one")

endmodule
`default_nettype wire

// ===== rtl/core/hsl_inter.sv =====
// clamping and the shared intermediates t1, t2 and their difference, stages one to three
`default_nettype none
module hsl_inter import hsl_pkg::*; (
  input  wire logic             clk_i,
  input  wire pipe_en_t         en_i,
  input  wire logic [HUE_W-1:0] hue_i,
  input  wire logic [VAL_W-1:0] saturation_i,
  input  wire logic [VAL_W-1:0] lightness_i,
  output logic      [HUE_W-1:0] x_red_o,
  output logic      [HUE_W-1:0] x_green_o,
  output logic      [HUE_W-1:0] x_blue_o,
  output logic      [VAL_W-1:0] d_o,
  output logic      [VAL_W-1:0] t1_o,
  output logic      [VAL_W-1:0] t2_o,
  output logic      [VAL_W-1:0] light_o,
  output logic                  grey_o
);

  logic [VAL_W-1:0] s_c, l_c;
  logic             low_c;
  logic [VAL_W:0]   mul_b;

  // stage one
  logic [VAL_W-1:0] s1_s_q, s1_l_q;
  logic [P1_W-1:0]  s1_prod_q;
  logic             s1_low_q, s1_grey_q;
  logic [HUE_W-1:0] s1_xr_q, s1_xg_q, s1_xb_q;

  // stage two
  logic [VAL_W+1:0] p_hi, t2_wide;
  logic [VAL_W:0]   sum_ls, t1_wide;
  logic [VAL_W-1:0] t2_d, t1_d;
  logic [VAL_W-1:0] s2_t1_q, s2_t2_q, s2_d_q, s2_l_q;
  logic             s2_grey_q;

  // stage three
  logic [VAL_W-1:0] s3_t1_q, s3_t2_q, s3_l_q;
  logic             s3_grey_q;

  always_comb begin
    s_c   = (saturation_i > ONE) ? ONE : saturation_i;
    l_c   = (lightness_i > ONE) ? ONE : lightness_i;
    low_c = {l_c, 1'b0} < {1'b0, ONE};
    mul_b = low_c ? ({1'b0, ONE} + {1'b0, s_c}) : {1'b0, s_c};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      s1_s_q    <= s_c;
      s1_l_q    <= l_c;
      s1_low_q  <= low_c;
      s1_grey_q <= (s_c == '0);
      s1_prod_q <= P1_W'(l_c) * P1_W'(mul_b);
      s1_xr_q   <= hue_i + THIRD;
      s1_xg_q   <= hue_i;
      s1_xb_q   <= hue_i + ONE_MINUS_THIRD;
    end
  end

  always_comb begin
    p_hi    = s1_prod_q[P1_W-1:FRAC_BITS];
    sum_ls  = {1'b0, s1_l_q} + {1'b0, s1_s_q};
    t2_wide = s1_low_q ? p_hi : ({1'b0, sum_ls} - p_hi);
    t2_d    = t2_wide[VAL_W-1:0];
    t1_wide = {s1_l_q, 1'b0} - {1'b0, t2_d};
    t1_d    = t1_wide[VAL_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      s2_t1_q   <= t1_d;
      s2_t2_q   <= t2_d;
      s2_d_q    <= t2_d - t1_d;
      s2_l_q    <= s1_l_q;
      s2_grey_q <= s1_grey_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      s3_t1_q   <= s2_t1_q;
      s3_t2_q   <= s2_t2_q;
      s3_l_q    <= s2_l_q;
      s3_grey_q <= s2_grey_q;
    end
  end

  assign x_red_o   = s1_xr_q;
  assign x_green_o = s1_xg_q;
  assign x_blue_o  = s1_xb_q;
  assign d_o       = s2_d_q;
  assign t1_o      = s3_t1_q;
  assign t2_o      = s3_t2_q;
  assign light_o   = s3_l_q;
  assign grey_o    = s3_grey_q;

endmodule
`default_nettype wire

// ===== rtl/core/hsl_chan.sv =====
// hue ramp for one color channel, stages two to four
`default_nettype none
module hsl_chan import hsl_pkg::*; (
  input  wire logic             clk_i,
  input  wire pipe_en_t         en_i,
  input  wire logic [HUE_W-1:0] x_i,
  input  wire logic [VAL_W-1:0] d_i,
  input  wire logic [VAL_W-1:0] t1_i,
  input  wire logic [VAL_W-1:0] t2_i,
  input  wire logic [VAL_W-1:0] light_i,
  input  wire logic             grey_i,
  output logic      [VAL_W-1:0] value_o
);

  logic [X6_W-1:0]  x6;
  logic [HUE_W+1:0] x3;
  logic [X6_W-1:0]  fall_m;
  seg_e             seg_d;
  logic [VAL_W-1:0] m_d;

  seg_e             s2_seg_q, s3_seg_q;
  logic [VAL_W-1:0] s2_m_q;
  logic [P3_W-1:0]  s3_prod_q;
  logic [VAL_W+1:0] ramp_sum;
  logic [VAL_W-1:0] value_d, value_q;

  always_comb begin
    x6     = (X6_W'(x_i) << 2) + (X6_W'(x_i) << 1);
    x3     = {2'b0, x_i} + {1'b0, x_i, 1'b0};
    fall_m = (X6_W'(ONE) << 2) - x6;
    m_d    = '0;
    if (x6 < X6_W'(ONE)) begin
      seg_d = SEG_RISE;
      m_d   = x6[VAL_W-1:0];
    end else if (!x_i[HUE_W-1]) begin
      seg_d = SEG_HIGH;
    end else if (x3 < ((HUE_W+2)'(ONE) << 1)) begin
      seg_d = SEG_FALL;
      m_d   = fall_m[VAL_W-1:0];
    end else begin
      seg_d = SEG_LOW;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      s2_seg_q <= seg_d;
      s2_m_q   <= m_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      s3_seg_q  <= s2_seg_q;
      s3_prod_q <= P3_W'(d_i) * P3_W'(s2_m_q);
    end
  end

  always_comb begin
    ramp_sum = {2'b0, t1_i} + s3_prod_q[P3_W-1:FRAC_BITS];
    if (grey_i) begin
      value_d = light_i;
    end else begin
      case (s3_seg_q)
        SEG_RISE, SEG_FALL: value_d = ramp_sum[VAL_W-1:0];
        SEG_HIGH:           value_d = t2_i;
        SEG_LOW:            value_d = t1_i;
        default:            value_d = t1_i;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// testbench for the hsl to rgb converter: corner and random pixels checked against a bit-true model
module tb_top import hsl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned RANDOM_COUNT = 1030;
  localparam int unsigned CALM_TAIL    = 150;

  typedef logic [47:0] wide_t;

  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [VAL_W-1:0] sat;
    logic [VAL_W-1:0] light;
  } hsl_t;

  typedef struct {
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] blue;
  } rgb_t;

  class color_scoreboard;
    rgb_t        rgb_due_q[$];
    int unsigned pixels_in;
    int unsigned beats_checked;
    int unsigned mismatches;

    function wide_t unit_val();
      return wide_t'(1) << FRAC_BITS;
    endfunction

    function seg_e hue_segment(logic [HUE_W-1:0] x);
      wide_t xw;
      xw = wide_t'(x);
      if (xw * 6 < unit_val()) return SEG_RISE;
      if (xw * 2 < unit_val()) return SEG_HIGH;
      if (xw * 3 < 2 * unit_val()) return SEG_FALL;
      return SEG_LOW;
    endfunction

    function logic [VAL_W-1:0] channel_level(wide_t lo, wide_t hi, logic [HUE_W-1:0] x);
      wide_t span;
      wide_t x6;
      wide_t level;
      span = hi - lo;
      x6   = wide_t'(x) * 6;
      case (hue_segment(x))
        SEG_RISE: level = lo + ((span * x6) >> FRAC_BITS);
        SEG_HIGH: level = hi;
        SEG_FALL: level = lo + ((span * (4 * unit_val() - x6)) >> FRAC_BITS);
        default:  level = lo;
      endcase
      return level[VAL_W-1:0];
    endfunction

    function rgb_t hsl_to_rgb(hsl_t px);
      logic [VAL_W-1:0] s;
      logic [VAL_W-1:0] l;
      wide_t            sw;
      wide_t            lw;
      wide_t            t1;
      wide_t            t2;
      rgb_t             c;
      s = (px.sat > ONE) ? ONE : px.sat;
      l = (px.light > ONE) ? ONE : px.light;
      if (s == '0) begin
        c.red   = l;
        c.green = l;
        c.blue  = l;
      end else begin
        sw = wide_t'(s);
        lw = wide_t'(l);
        if (2 * lw < unit_val()) begin
          t2 = (lw * (unit_val() + sw)) >> FRAC_BITS;
        end else begin
          t2 = lw + sw - ((sw * lw) >> FRAC_BITS);
        end
        t1 = 2 * lw - t2;
        // the third-turn offsets wrap in the hue width
        c.red   = channel_level(t1, t2, px.hue + THIRD);
        c.green = channel_level(t1, t2, px.hue);
        c.blue  = channel_level(t1, t2, px.hue - THIRD);
      end
      return c;
    endfunction

    function void note_pixel(hsl_t px);
      rgb_due_q.push_back(hsl_to_rgb(px));
      pixels_in++;
    endfunction

    function void check_rgb(rgb_t got);
      rgb_t want;
      if (rgb_due_q.size() == 0) begin
        $error("rgb beat with no pixel pending: red %0d green %0d blue %0d",
               got.red, got.green, got.blue);
        mismatches++;
        return;
      end
      want = rgb_due_q.pop_front();
      beats_checked++;
      if (got.red !== want.red) begin
        $error("red: expected %0d, got %0d", want.red, got.red);
        mismatches++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, got %0d", want.green, got.green);
        mismatches++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, got.blue);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return rgb_due_q.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_valid = 1'b0;
  logic [IN_W-1:0]  s_data = '0;
  logic             m_ready = 1'b0;
  logic             s_axis_tready_o;
  logic             m_axis_tvalid_o;
  logic [OUT_W-1:0] m_axis_tdata_o;

  color_scoreboard  sb;
  int unsigned      stall_pct = 0;
  int unsigned      quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hsl_to_rgb_converter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // receiver side: random stall bursts while stall_pct is nonzero
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) < stall_pct) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    rgb_t got;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got.red   = m_axis_tdata_o[VAL_W-1:0];
      got.green = m_axis_tdata_o[2*VAL_W-1:VAL_W];
      got.blue  = m_axis_tdata_o[3*VAL_W-1:2*VAL_W];
      sb.check_rgb(got);
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no beat moved for %0d cycles", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(logic [HUE_W-1:0] h, logic [VAL_W-1:0] s, logic [VAL_W-1:0] l);
    hsl_t px;
    px.hue   = h;
    px.sat   = s;
    px.light = l;
    if ($urandom_range(0, 99) < stall_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_data  <= IN_W'({l, s, h});
    s_valid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_pixel(px);
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [HUE_W-1:0] pick_hue();
    logic [HUE_W-1:0] edges[8] = '{16'd0, 16'd10922, 16'd21845, 16'd32768,
                                   16'd43690, 16'd43691, 16'd54613, 16'd65535};
    if ($urandom_range(0, 9) == 0) begin
      return edges[$urandom_range(0, 7)] + HUE_W'($urandom_range(0, 2)) - HUE_W'(1);
    end
    return HUE_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value(bit near_half);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return VAL_W'($urandom_range(65536, 131071));
      2:       return VAL_W'($urandom_range(1, 16));
      3:       return near_half ? VAL_W'($urandom_range(32766, 32770)) : ONE;
      default: return VAL_W'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // grey, clamping, full-saturation, lightness-half and hue segment edge corners
    send_pixel(16'd0, 17'd0, 17'd0);
    send_pixel(16'd65535, 17'd0, 17'd65536);
    send_pixel(16'd12345, 17'd0, 17'd131071);
    send_pixel(16'd0, 17'd65536, 17'd32768);
    send_pixel(16'd21845, 17'd65536, 17'd32768);
    send_pixel(16'd43691, 17'd65536, 17'd32768);
    send_pixel(16'd43690, 17'd131071, 17'd40000);
    send_pixel(16'd5000, 17'd1, 17'd32768);
    send_pixel(16'd5000, 17'd40000, 17'd32767);
    send_pixel(16'd5000, 17'd40000, 17'd32768);
    send_pixel(16'd10922, 17'd50000, 17'd20000);
    send_pixel(16'd10923, 17'd50000, 17'd20000);
    send_pixel(16'd32767, 17'd50000, 17'd50000);
    send_pixel(16'd32768, 17'd50000, 17'd50000);
    send_pixel(16'd54613, 17'd65536, 17'd65536);
    send_pixel(16'd65535, 17'd65536, 17'd0);
    send_pixel(16'd65535, 17'd65536, 17'd65535);
    send_pixel(16'd30000, 17'd131071, 17'd131071);
    send_pixel(16'd1, 17'd65535, 17'd1);
    send_pixel(16'd65535, 17'd131071, 17'd131071);
    drain_results();

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i == RANDOM_COUNT / 2) drain_results();
      if (i >= RANDOM_COUNT - CALM_TAIL) begin
        stall_pct = 0;
      end else if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 5;
          2:       stall_pct = 20;
          default: stall_pct = 40;
        endcase
      end
      send_pixel(pick_hue(), pick_value(1'b0), pick_value(1'b1));
    end
    s_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d pixels sent, %0d rgb beats checked field by field", sb.pixels_in,
             sb.beats_checked);
    $display("covered grey, clamped inputs, hue segment edges and wrapped offsets under stalls");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
